>>> rtl/ptts_pkg.sv
`timescale 1ns / 1ps
package ptts_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 8;
  localparam int unsigned TASK_W         = 6;
  localparam int unsigned TIME_W         = 32;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_SUSPEND = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RC_OK       = 2'd0,
    RC_OCCUPIED = 2'd1,
    RC_RANGE    = 2'd2,
    RC_NOTASK   = 2'd3
  } rc_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY     = 2'd0,
    SLOT_RUNNING   = 2'd1,
    SLOT_SUSPENDED = 2'd2
  } slot_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // take the input word, restart the scan
    logic exec_cmd;   // apply a slot command and load its answer
    logic eval_step;  // settle the scanned slot and move on
    logic finish;     // load the closing tick result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic slot_running;
    logic slot_fire;
    logic pend_valid;
    logic out_free;
    logic scan_last;
  } stat_t;

endpackage

>>> rtl/ptts_intf.sv
`timescale 1ns / 1ps
interface ptts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  task_index;
  logic [31:0] period;
  logic [31:0] first_delay;

  modport source(output valid, command, task_index, period, first_delay, input ready);
  modport sink(input valid, command, task_index, period, first_delay, output ready);
endinterface

interface ptts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       fire_valid;
  logic [5:0] fired_task;
  logic       last;

  modport source(output valid, status, fire_valid, fired_task, last, input ready);
  modport sink(input valid, status, fire_valid, fired_task, last, output ready);
endinterface

>>> rtl/ptts_ctrl.sv
`timescale 1ns / 1ps
module ptts_ctrl
  import ptts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMD  = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   stall;

  // a fire with an older fire pending pushes that one out: needs a free output
  assign stall = stat_i.slot_running && stat_i.slot_fire && stat_i.pend_valid &&
                 !stat_i.out_free;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_CMD;
        end
      end
      S_CMD: begin
        if (stat_i.is_tick) begin
          state_d = S_RD;
        end else if (stat_i.out_free) begin
          ctl_o.exec_cmd = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        if (!stall) begin
          ctl_o.eval_step = 1'b1;
          if (stat_i.scan_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/ptts_datapath.sv
`timescale 1ns / 1ps
module ptts_datapath
  import ptts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  output stat_t             stat_o,
  input  logic [2:0]        command_i,
  input  logic [7:0]        task_index_i,
  input  logic [TIME_W-1:0] period_i,
  input  logic [TIME_W-1:0] first_delay_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic              fire_valid_o,
  output logic [TASK_W-1:0] fired_task_o,
  output logic              last_o
);

  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  // latched input word
  logic [2:0]        cmd_q;
  logic [7:0]        index_q;
  logic [TIME_W-1:0] period_q, delay_q;

  // slot states, period and countdown memories
  slot_e             slot_q [TASK_SLOTS];
  logic [TIME_W-1:0] per_mem [TASK_SLOTS];
  logic [TIME_W-1:0] cd_mem  [TASK_SLOTS];
  logic [TIME_W-1:0] per_rd_q, cd_rd_q;

  // scan state
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;

  // output register
  logic              out_valid_q;
  logic [1:0]        status_q, status_d;
  logic              fire_q, fire_d;
  logic [TASK_W-1:0] task_q, task_d;
  logic              last_q, last_d;
  logic              out_load;

  logic              in_range;
  logic [IDX_W-1:0]  slot_sel;
  slot_e             cur_slot;
  slot_e             new_slot;
  logic              slot_we;
  rc_e               rc;
  logic              scan_run, scan_fire, scan_last;
  logic              per_we, cd_we;
  logic [TIME_W-1:0] per_wdata, cd_wdata;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  assign in_range  = (index_q < 8'(TASK_SLOTS));
  assign slot_sel  = index_q[IDX_W-1:0];
  assign cur_slot  = slot_q[slot_sel];
  assign scan_run  = (slot_q[idx_q] == SLOT_RUNNING);
  assign scan_fire = (cd_rd_q == '0) || (cd_rd_q > per_rd_q);
  assign scan_last = (idx_q == LAST_IDX);

  assign stat_o.is_tick      = (cmd_q == CMD_TICK);
  assign stat_o.slot_running = scan_run;
  assign stat_o.slot_fire    = scan_fire;
  assign stat_o.pend_valid   = pend_valid_q;
  assign stat_o.out_free     = !out_valid_q || out_ready_i;
  assign stat_o.scan_last    = scan_last;

  // slot commands
  always_comb begin
    rc        = RC_OK;
    new_slot  = cur_slot;
    slot_we   = 1'b0;
    per_we    = 1'b0;
    per_wdata = period_q;
    if (ctl_i.exec_cmd && (cmd_q <= CMD_DELETE) && !in_range) begin
      rc = RC_RANGE;
    end else if (ctl_i.exec_cmd) begin
      case (cmd_q)
        CMD_CREATE: begin
          if (cur_slot == SLOT_EMPTY) begin
            new_slot = SLOT_RUNNING;
            slot_we  = 1'b1;
            per_we   = 1'b1;
          end else begin
            rc = RC_OCCUPIED;
          end
        end
        CMD_SUSPEND: begin
          if (cur_slot == SLOT_RUNNING) begin
            new_slot = SLOT_SUSPENDED;
            slot_we  = 1'b1;
          end else begin
            rc = RC_NOTASK;
          end
        end
        CMD_RESUME: begin
          if (cur_slot == SLOT_SUSPENDED) begin
            new_slot = SLOT_RUNNING;
            slot_we  = 1'b1;
          end else begin
            rc = RC_NOTASK;
          end
        end
        CMD_DELETE: begin
          if (cur_slot != SLOT_EMPTY) begin
            new_slot  = SLOT_EMPTY;
            slot_we   = 1'b1;
            per_we    = 1'b1;
            per_wdata = '0;
          end else begin
            rc = RC_NOTASK;
          end
        end
        default: begin
          rc = RC_OK;
        end
      endcase
    end
  end

  // countdown write: create loads the first delay, the scan reloads or counts down
  always_comb begin
    cd_we    = 1'b0;
    cd_wdata = delay_q;
    if (ctl_i.exec_cmd && slot_we && (cmd_q == CMD_CREATE)) begin
      cd_we = 1'b1;
    end else if (ctl_i.eval_step && scan_run) begin
      cd_we    = 1'b1;
      cd_wdata = scan_fire ? per_rd_q : (cd_rd_q - 1'b1);
    end
  end

  assign wr_addr = ctl_i.exec_cmd ? slot_sel : idx_q;
  // read one slot ahead while the current one settles
  assign rd_addr = (ctl_i.eval_step && !scan_last) ? (idx_q + 1'b1) : idx_q;

  // scan progress and result staging
  always_comb begin
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    out_load     = 1'b0;
    status_d     = status_q;
    fire_d       = fire_q;
    task_d       = task_q;
    last_d       = last_q;
    if (ctl_i.capture) begin
      idx_d        = '0;
      pend_valid_d = 1'b0;
    end
    if (ctl_i.exec_cmd) begin
      out_load = 1'b1;
      status_d = rc;
      fire_d   = 1'b0;
      task_d   = '0;
      last_d   = 1'b1;
    end
    if (ctl_i.eval_step) begin
      if (!scan_last) begin
        idx_d = idx_q + 1'b1;
      end
      if (scan_run && scan_fire) begin
        // hold the newest fire back until the next one shows whether it is last
        if (pend_valid_q) begin
          out_load = 1'b1;
          status_d = RC_OK;
          fire_d   = 1'b1;
          task_d   = TASK_W'(pend_idx_q);
          last_d   = 1'b0;
        end
        pend_valid_d = 1'b1;
        pend_idx_d   = idx_q;
      end
    end
    if (ctl_i.finish) begin
      out_load = 1'b1;
      status_d = RC_OK;
      fire_d   = pend_valid_q;
      task_d   = pend_valid_q ? TASK_W'(pend_idx_q) : '0;
      last_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q    <= command_i;
      index_q  <= task_index_i;
      period_q <= period_i;
      delay_q  <= first_delay_i;
    end
    if (per_we) begin
      per_mem[wr_addr] <= per_wdata;
    end
    if (cd_we) begin
      cd_mem[wr_addr] <= cd_wdata;
    end
    per_rd_q   <= per_mem[rd_addr];
    cd_rd_q    <= cd_mem[rd_addr];
    pend_idx_q <= pend_idx_d;
    status_q   <= status_d;
    fire_q     <= fire_d;
    task_q     <= task_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_q[i] <= SLOT_EMPTY;
      end
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (slot_we) begin
        slot_q[slot_sel] <= new_slot;
      end
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign fire_valid_o = fire_q;
  assign fired_task_o = task_q;
  assign last_o       = last_q;

endmodule

>>> rtl/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// Time-triggered task scheduler with TASK_SLOTS slots, one per priority index.
// Send a word on req_i: create (0), suspend (1), resume (2), delete (3) or
// tick (4). Each slot command answers with one word carrying its status code
// (ok, occupied, out of range, no such task) and last set. A tick walks the
// slots in index order: a running slot whose countdown is zero or above its
// period fires and reloads with the period, any other running slot counts
// down. Each fire gives one word with fire_valid and fired_task, in ascending
// order, last set on the final one; a tick that fires nothing gives a single
// word with fire_valid low. Words are taken one at a time. A slot command
// steps through accept and execute, execute waiting for a free output. A
// tick steps through accept, decode of the command, priming of the read, the
// scan and the closing word, which waits for a free output. The scan settles
// one slot per cycle through the single read port of the period and countdown
// memories, unless a fire must push out a held fire while the output is full.
// A fire is held back by one fire so its last flag is known, and a new word is
// accepted while the final result still waits in the output register.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptts_req_if.sink   req_i,
  ptts_rsp_if.source rsp_o
);

  ctl_t  ctl;
  stat_t stat;

  // sequencer: accept, execute or scan, close
  ptts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // slot table, memories and output register
  ptts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .command_i     (req_i.command),
    .task_index_i  (req_i.task_index),
    .period_i      (req_i.period),
    .first_delay_i (req_i.first_delay),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .fire_valid_o  (rsp_o.fire_valid),
    .fired_task_o  (rsp_o.fired_task),
    .last_o        (rsp_o.last)
  );

endmodule

>>> sim/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
module tb_periodic_task_tick_scheduler;
  import ptts_pkg::*;

  localparam int SLOTS       = TASK_SLOTS_DEF;
  localparam int DIR_ROWS    = 25;
  localparam int RAND_WORDS  = 84;
  localparam int HOLD_CYCLES = 90;
  localparam int CYCLE_LIMIT = 200000;
  // Tick scan plus closing word, with margin for the drain at the end.
  localparam int DRAIN_CYCLES = SLOTS + 12;

  // Command codes the block leaves unused; it must still answer them.
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  typedef struct packed {
    rc_e        status;
    logic       fire_valid;
    logic [5:0] fired_task;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  idx;
    logic [31:0] per;
    logic [31:0] dly;
    logic        pinned;  // use the answer typed in below, not the predictor's
    result_t     want;
  } stim_t;

  // Answers that can be read straight off the command rules.
  localparam result_t R_DONE     = '{RC_OK,       1'b0, 6'd0, 1'b1};
  localparam result_t R_OCCUPIED = '{RC_OCCUPIED, 1'b0, 6'd0, 1'b1};
  localparam result_t R_RANGE    = '{RC_RANGE,    1'b0, 6'd0, 1'b1};
  localparam result_t R_NOTASK   = '{RC_NOTASK,   1'b0, 6'd0, 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni;

  ptts_req_if req_if ();
  ptts_rsp_if rsp_if ();

  periodic_task_tick_scheduler #(
    .TASK_SLOTS(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the slot table, advanced once per accepted word.
  slot_e       slot_state  [SLOTS];
  logic [31:0] slot_reload [SLOTS];
  logic [31:0] slot_count  [SLOTS];

  // Answers still owed by the block, oldest first.
  result_t due_q[$];

  int   error_count  = 0;
  int   cycle_count  = 0;
  int   words_sent   = 0;
  int   ticks_sent   = 0;
  int   fires_seen   = 0;
  int   burst        = 0;
  int   widest_burst = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  logic hold_rsp     = 1'b0;
  result_t got;
  result_t want;

  // Work out what one accepted word produces and queue it. Ticks scan the
  // slots in index order; a running slot fires when its countdown is zero or
  // has drifted above its period, and reloads with the period.
  function automatic void predict_word(logic [2:0] cmd, logic [7:0] idx,
                                       logic [31:0] per, logic [31:0] dly);
    rc_e rc;
    int  fired;
    int  si;
    rc    = RC_OK;
    fired = 0;
    si    = idx;
    if (cmd == CMD_TICK) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_state[s] == SLOT_RUNNING) begin
          if (slot_count[s] == 32'd0 || slot_count[s] > slot_reload[s]) begin
            slot_count[s] = slot_reload[s];
            due_q.push_back('{RC_OK, 1'b1, 6'(s), 1'b0});
            fired++;
          end else begin
            slot_count[s] = slot_count[s] - 32'd1;
          end
        end
      end
      // Mark the final fire, or answer a quiet tick with a single word.
      if (fired == 0) due_q.push_back(R_DONE);
      else due_q[due_q.size() - 1].last = 1'b1;
      return;
    end
    if (cmd <= CMD_DELETE) begin
      if (si >= SLOTS) begin
        rc = RC_RANGE;
      end else begin
        case (cmd)
          CMD_CREATE: begin
            if (slot_state[si] == SLOT_EMPTY) begin
              slot_state[si]  = SLOT_RUNNING;
              slot_reload[si] = per;
              slot_count[si]  = dly;
            end else begin
              rc = RC_OCCUPIED;
            end
          end
          CMD_SUSPEND: begin
            if (slot_state[si] == SLOT_RUNNING) slot_state[si] = SLOT_SUSPENDED;
            else rc = RC_NOTASK;
          end
          CMD_RESUME: begin
            if (slot_state[si] == SLOT_SUSPENDED) slot_state[si] = SLOT_RUNNING;
            else rc = RC_NOTASK;
          end
          default: begin
            // Delete clears the period; the countdown is left as it was.
            if (slot_state[si] != SLOT_EMPTY) begin
              slot_state[si]  = SLOT_EMPTY;
              slot_reload[si] = 32'd0;
            end else begin
              rc = RC_NOTASK;
            end
          end
        endcase
      end
    end
    due_q.push_back('{rc, 1'b0, 6'd0, 1'b1});
  endfunction

  // Offer one word from the falling edge, with random idle cycles ahead of
  // it, and hold it until the block takes it. Returns on the next falling
  // edge with valid still high, so back-to-back words need no re-raise.
  task automatic send_word(input stim_t w);
    int mark;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.command     = w.cmd;
    req_if.task_index  = w.idx;
    req_if.period      = w.per;
    req_if.first_delay = w.dly;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    mark = due_q.size();
    predict_word(w.cmd, w.idx, w.per, w.dly);
    if (w.pinned) begin
      // Keep the shadow state moving but check against the typed answer.
      while (due_q.size() > mark) void'(due_q.pop_back());
      due_q.push_back(w.want);
    end
    words_sent++;
    if (w.cmd == CMD_TICK) ticks_sent++;
    @(negedge clk_i);
  endtask

  // Receiver: drop ready at random, or hold it low for a long stretch when
  // asked, so the block backs up and stalls its input.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      rsp_if.ready = rst_ni && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status     = rc_e'(rsp_if.status);
      got.fire_valid = rsp_if.fire_valid;
      got.fired_task = rsp_if.fired_task;
      got.last       = rsp_if.last;
      if (due_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status=%0d fire=%0b task=%0d last=%0b",
                 $time, got.status, got.fire_valid, got.fired_task, got.last);
      end else begin
        want = due_q.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t: mismatch expected status=%0d fire=%0b task=%0d last=%0b",
                   $time, want.status, want.fire_valid, want.fired_task, want.last);
          $display("%0t:          actual   status=%0d fire=%0b task=%0d last=%0b",
                   $time, got.status, got.fire_valid, got.fired_task, got.last);
        end
      end
      if (got.fire_valid) begin
        fires_seen++;
        burst++;
      end
      if (got.last) begin
        if (burst > widest_burst) widest_burst = burst;
        burst = 0;
      end
    end
  end

  // Watchdog: end the run if the block hangs anywhere.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time, due_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_t plan [DIR_ROWS];
    stim_t w;
    int    sent;
    int    pick;

    // Directed table: error codes, field extremes, period zero, a countdown
    // above its period, suspend/resume in the wrong state, unused commands.
    plan = '{
      '{CMD_TICK,       8'd0,   32'd0,        32'd0,        1'b1, R_DONE},
      '{CMD_SUSPEND,    8'd0,   32'd0,        32'd0,        1'b1, R_NOTASK},
      '{CMD_RESUME,     8'd0,   32'd0,        32'd0,        1'b1, R_NOTASK},
      '{CMD_DELETE,     8'd0,   32'd0,        32'd0,        1'b1, R_NOTASK},
      '{CMD_CREATE,     8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, R_RANGE},
      '{CMD_SUSPEND,    8'd8,   32'd0,        32'd0,        1'b1, R_RANGE},
      '{CMD_CREATE,     8'd0,   32'd0,        32'd0,        1'b1, R_DONE},
      '{CMD_CREATE,     8'd0,   32'd3,        32'd3,        1'b1, R_OCCUPIED},
      '{CMD_CREATE,     8'd7,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, R_DONE},
      '{CMD_CREATE,     8'd3,   32'd2,        32'd5,        1'b1, R_DONE},
      '{CMD_TICK,       8'd170, 32'd0,        32'd0,        1'b0, R_DONE},
      '{CMD_CREATE,     8'd5,   32'd1,        32'd1,        1'b1, R_DONE},
      '{CMD_TICK,       8'd85,  32'd0,        32'd0,        1'b0, R_DONE},
      '{CMD_SUSPEND,    8'd3,   32'd0,        32'd0,        1'b1, R_DONE},
      '{CMD_SUSPEND,    8'd3,   32'd0,        32'd0,        1'b1, R_NOTASK},
      '{CMD_RESUME,     8'd0,   32'd0,        32'd0,        1'b1, R_NOTASK},
      '{CMD_TICK,       8'd0,   32'd0,        32'd0,        1'b0, R_DONE},
      '{CMD_RESUME,     8'd3,   32'd0,        32'd0,        1'b1, R_DONE},
      '{CMD_DELETE,     8'd7,   32'd0,        32'd0,        1'b1, R_DONE},
      '{CMD_UNUSED_LO,  8'd0,   32'd0,        32'd0,        1'b1, R_DONE},
      '{CMD_UNUSED_HI,  8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, R_DONE},
      '{CMD_UNUSED_MID, 8'd3,   32'd1,        32'd1,        1'b1, R_DONE},
      '{CMD_TICK,       8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, R_DONE},
      '{CMD_DELETE,     8'd0,   32'd0,        32'd0,        1'b1, R_DONE},
      '{CMD_RESUME,     8'd200, 32'd0,        32'd0,        1'b1, R_RANGE}
    };

    for (int s = 0; s < SLOTS; s++) begin
      slot_state[s]  = SLOT_EMPTY;
      slot_reload[s] = 32'd0;
      slot_count[s]  = 32'd0;
    end

    // Drive every input to a known value before reset lets go.
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.command     = CMD_TICK;
    req_if.task_index  = 8'd0;
    req_if.period      = 32'd0;
    req_if.first_delay = 32'd0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Sender sparse-ish, receiver often stalled for the directed rows.
    src_idle_pct = 18;
    snk_idle_pct = 47;
    for (int r = 0; r < DIR_ROWS; r++) send_word(plan[r]);

    // Random part in three phases: sender 18% / receiver 47% idle, then
    // swapped, then both flat out with one long receiver hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 18;
          snk_idle_pct = 47;
        end
        1: begin
          src_idle_pct = 47;
          snk_idle_pct = 18;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          hold_rsp     = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < (RAND_WORDS + 2) / 3) begin
        // Mostly in-range slot traffic with small periods so tasks fire
        // often; a few full-width values, bad indexes and unused codes.
        pick     = $urandom_range(0, 99);
        w        = '0;
        w.idx    = 8'($urandom_range(0, SLOTS - 1));
        w.per    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
        w.dly    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 9);
        if (pick < 35) begin
          w.cmd = CMD_TICK;
          w.idx = 8'($urandom);
        end else if (pick < 58) begin
          w.cmd = CMD_CREATE;
        end else if (pick < 68) begin
          w.cmd = CMD_SUSPEND;
        end else if (pick < 78) begin
          w.cmd = CMD_RESUME;
        end else if (pick < 86) begin
          w.cmd = CMD_DELETE;
        end else if (pick < 95) begin
          w.cmd = 3'($urandom_range(CMD_CREATE, CMD_DELETE));
          w.idx = 8'($urandom_range(SLOTS, 255));
        end else begin
          w.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
          w.idx = 8'($urandom);
        end
        send_word(w);
        if (w.cmd <= CMD_TICK) sent++;
      end
    end
    req_if.valid = 1'b0;

    // Drain: wait for every owed answer, then watch for stray words.
    while (due_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d ticks) across three idle patterns and a %0d-cycle stall;",
             words_sent, ticks_sent, HOLD_CYCLES);
    $display("checked %0d fires, up to %0d slots firing on one tick.",
             fires_seen, widest_burst);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ptts_pkg.sv
rtl/ptts_intf.sv
rtl/ptts_ctrl.sv
rtl/ptts_datapath.sv
rtl/periodic_task_tick_scheduler.sv
sim/tb_periodic_task_tick_scheduler.sv
